// ----- src/rts_pkg.sv -----
// Shared types, codes and packing functions for the I2C register transaction sequencer.
`default_nettype none
package rts_pkg;

   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 24;

   typedef enum logic [1:0] {
      FUNC_WRITE   = 2'd0,
      FUNC_READ    = 2'd1,
      FUNC_DONE    = 2'd2,
      FUNC_PAYLOAD = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      CMD_NONE  = 3'd0,
      CMD_START = 3'd1,
      CMD_SEND  = 3'd2,
      CMD_CHECK = 3'd3,
      CMD_RECV  = 3'd4,
      CMD_ACK   = 3'd5,
      CMD_NACK  = 3'd6,
      CMD_STOP  = 3'd7
   } cmd_type;

   typedef enum logic [1:0] {
      ST_BUSY   = 2'd0,
      ST_OK     = 2'd1,
      ST_ABORT  = 2'd2,
      ST_REJECT = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      PH_IDLE      = 4'd0,
      PH_START1    = 4'd1,
      PH_AW_SEND   = 4'd2,
      PH_AW_ACK    = 4'd3,
      PH_REG_SEND  = 4'd4,
      PH_REG_ACK   = 4'd5,
      PH_WAIT_DATA = 4'd6,
      PH_D_SEND    = 4'd7,
      PH_D_ACK     = 4'd8,
      PH_START2    = 4'd9,
      PH_AR_SEND   = 4'd10,
      PH_AR_ACK    = 4'd11,
      PH_RECV      = 4'd12,
      PH_ACKOUT    = 4'd13,
      PH_STOP      = 4'd14
   } phase_type;

   typedef struct packed {
      func_type    func;
      logic [6:0]  slave_address;
      logic [15:0] register_address;
      logic        wide_register;
      logic [7:0]  byte_count;
      logic        nack_seen;
      logic [7:0]  received_byte;
      logic [7:0]  payload_byte;
   } req_type;

   typedef struct packed {
      cmd_type     bus_command;
      logic [7:0]  send_byte;
      logic        data_request;
      logic        read_valid;
      logic [7:0]  read_byte;
      logic        finished;
      status_type  status;
   } rsp_type;

   function automatic req_type unpack_req(input logic [1:0] user,
                                          input logic [REQ_DATA_W-1:0] data);
      req_type r;
      r.func             = func_type'(user);
      r.slave_address    = data[6:0];
      r.register_address = data[22:7];
      r.wide_register    = data[23];
      r.byte_count       = data[31:24];
      r.nack_seen        = data[32];
      r.received_byte    = data[40:33];
      r.payload_byte     = data[48:41];
      return r;
   endfunction

   function automatic logic [RSP_DATA_W-1:0] pack_rsp(input rsp_type r);
      return {r.status, r.finished, r.read_byte, r.read_valid, r.data_request,
              r.send_byte, r.bus_command};
   endfunction

   function automatic rsp_type unpack_rsp(input logic [RSP_DATA_W-1:0] data);
      rsp_type r;
      r.bus_command  = cmd_type'(data[2:0]);
      r.send_byte    = data[10:3];
      r.data_request = data[11];
      r.read_valid   = data[12];
      r.read_byte    = data[20:13];
      r.finished     = data[21];
      r.status       = status_type'(data[23:22]);
      return r;
   endfunction

endpackage
`default_nettype wire

// ----- src/i2c_register_transaction_sequencer.sv -----
// Top level of the I2C register transaction sequencer.
//
//   channel | direction | handshake                 | content
//   req     | in        | req_tvalid / req_tready   | request, completion or payload item
//   rsp     | out       | rsp_tvalid / rsp_tready   | one result item per request item
//
// One item per cycle sustained while rsp does not stall; an accepted item is
// held in the input register, and its result is then held in the result
// register, which drives rsp.
// The next-command decision is a single combinational pass over the held
// item and the transaction state.
// Synchronous reset returns the sequencer to idle and empties both registers.
// A stall on rsp backs up into req only once both registers are full.
`default_nettype none
module i2c_register_transaction_sequencer
   import rts_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // [6:0] slave_address, [22:7] register_address, [23] wide_register,
   // [31:24] byte_count, [32] nack_seen, [40:33] received_byte,
   // [48:41] payload_byte, [55:49] zero
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // [1:0] func
   input  wire logic [1:0]            req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [2:0] bus_command, [10:3] send_byte, [11] data_request, [12] read_valid,
   // [20:13] read_byte, [21] finished, [23:22] status
   output logic [RSP_DATA_W-1:0]      rsp_tdata
);

   logic    item_valid;
   logic    take;
   req_type item;
   rsp_type result;

   rts_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .take       (take),
      .item_valid (item_valid),
      .item       (item)
   );

   rts_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (take),
      .item   (item),
      .result (result)
   );

   rts_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .result     (result),
      .take       (take),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
`default_nettype wire

// ----- src/rts_in_reg.sv -----
// Input register stage: holds one request item until the sequencer core takes it.
`default_nettype none
module rts_in_reg
   import rts_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic [1:0]            req_tuser,
   input  wire logic                  take,
   output logic                       item_valid,
   output req_type                    item
);

   logic    valid_ff, valid_in;
   req_type item_ff;

   assign req_tready = !valid_ff || take;
   assign valid_in   = req_tready ? req_tvalid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         item_ff <= unpack_req(req_tuser, req_tdata);
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule
`default_nettype wire

// ----- src/rts_core.sv -----
// Transaction state and next-command decision for one item per cycle while step is high.
`default_nettype none
module rts_core
   import rts_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    step,
   input  wire req_type item,
   output rsp_type      result
);

   phase_type   phase_ff, phase_in;
   logic        is_read_ff, is_read_in;
   logic [6:0]  target_ff, target_in;
   logic [15:0] reg_addr_ff, reg_addr_in;
   logic        two_byte_ff, two_byte_in;
   logic [7:0]  remaining_ff, remaining_in;
   logic        aborted_ff, aborted_in;
   logic        done;
   logic [7:0]  rem_dec;

   assign done    = (item.func == FUNC_DONE);
   assign rem_dec = remaining_ff - 8'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         is_read_ff   <= 1'b0;
         target_ff    <= '0;
         reg_addr_ff  <= '0;
         two_byte_ff  <= 1'b0;
         remaining_ff <= '0;
         aborted_ff   <= 1'b0;
      end else if (step) begin
         phase_ff     <= phase_in;
         is_read_ff   <= is_read_in;
         target_ff    <= target_in;
         reg_addr_ff  <= reg_addr_in;
         two_byte_ff  <= two_byte_in;
         remaining_ff <= remaining_in;
         aborted_ff   <= aborted_in;
      end
   end

   always_comb begin
      phase_in     = phase_ff;
      is_read_in   = is_read_ff;
      target_in    = target_ff;
      reg_addr_in  = reg_addr_ff;
      two_byte_in  = two_byte_ff;
      remaining_in = remaining_ff;
      aborted_in   = aborted_ff;
      result       = '0;

      unique case (phase_ff)
         PH_IDLE: begin
            if (item.func == FUNC_WRITE || item.func == FUNC_READ) begin
               if (item.byte_count == 8'd0) begin
                  result.finished = 1'b1;
                  result.status   = ST_REJECT;
               end else begin
                  is_read_in         = (item.func == FUNC_READ);
                  target_in          = item.slave_address;
                  reg_addr_in        = item.register_address;
                  two_byte_in        = item.wide_register;
                  remaining_in       = item.byte_count;
                  aborted_in         = 1'b0;
                  result.bus_command = CMD_START;
                  phase_in           = PH_START1;
               end
            end
         end
         PH_WAIT_DATA: begin
            if (item.func == FUNC_PAYLOAD) begin
               result.bus_command = CMD_SEND;
               result.send_byte   = item.payload_byte;
               phase_in           = PH_D_SEND;
            end
         end
         PH_START1: begin
            if (done) begin
               result.bus_command = CMD_SEND;
               result.send_byte   = {target_ff, 1'b0};
               phase_in           = PH_AW_SEND;
            end
         end
         PH_AW_SEND, PH_REG_SEND, PH_D_SEND, PH_AR_SEND: begin
            if (done) begin
               result.bus_command = CMD_CHECK;
               phase_in = (phase_ff == PH_AW_SEND)  ? PH_AW_ACK  :
                          (phase_ff == PH_REG_SEND) ? PH_REG_ACK :
                          (phase_ff == PH_D_SEND)   ? PH_D_ACK   : PH_AR_ACK;
            end
         end
         PH_AW_ACK: begin
            if (done) begin
               if (item.nack_seen) begin
                  aborted_in         = 1'b1;
                  result.bus_command = CMD_STOP;
                  phase_in           = PH_STOP;
               end else begin
                  result.bus_command = CMD_SEND;
                  result.send_byte   = reg_addr_ff[7:0];
                  phase_in           = PH_REG_SEND;
               end
            end
         end
         PH_REG_ACK: begin
            if (done) begin
               if (item.nack_seen) begin
                  aborted_in         = 1'b1;
                  result.bus_command = CMD_STOP;
                  phase_in           = PH_STOP;
               end else if (two_byte_ff) begin
                  // high register byte goes out second
                  two_byte_in        = 1'b0;
                  reg_addr_in        = {8'd0, reg_addr_ff[15:8]};
                  result.bus_command = CMD_SEND;
                  result.send_byte   = reg_addr_ff[15:8];
                  phase_in           = PH_REG_SEND;
               end else if (is_read_ff) begin
                  result.bus_command = CMD_START;
                  phase_in           = PH_START2;
               end else begin
                  result.data_request = 1'b1;
                  phase_in            = PH_WAIT_DATA;
               end
            end
         end
         PH_D_ACK: begin
            if (done) begin
               if (item.nack_seen) begin
                  aborted_in         = 1'b1;
                  result.bus_command = CMD_STOP;
                  phase_in           = PH_STOP;
               end else begin
                  remaining_in = rem_dec;
                  if (rem_dec == 8'd0) begin
                     result.bus_command = CMD_STOP;
                     phase_in           = PH_STOP;
                  end else begin
                     result.data_request = 1'b1;
                     phase_in            = PH_WAIT_DATA;
                  end
               end
            end
         end
         PH_START2: begin
            if (done) begin
               result.bus_command = CMD_SEND;
               result.send_byte   = {target_ff, 1'b1};
               phase_in           = PH_AR_SEND;
            end
         end
         PH_AR_ACK: begin
            if (done) begin
               if (item.nack_seen) begin
                  aborted_in         = 1'b1;
                  result.bus_command = CMD_STOP;
                  phase_in           = PH_STOP;
               end else begin
                  result.bus_command = CMD_RECV;
                  phase_in           = PH_RECV;
               end
            end
         end
         PH_RECV: begin
            if (done) begin
               result.read_valid  = 1'b1;
               result.read_byte   = item.received_byte;
               remaining_in       = rem_dec;
               result.bus_command = (rem_dec == 8'd0) ? CMD_NACK : CMD_ACK;
               phase_in           = PH_ACKOUT;
            end
         end
         PH_ACKOUT: begin
            if (done) begin
               if (remaining_ff == 8'd0) begin
                  result.bus_command = CMD_STOP;
                  phase_in           = PH_STOP;
               end else begin
                  result.bus_command = CMD_RECV;
                  phase_in           = PH_RECV;
               end
            end
         end
         PH_STOP: begin
            if (done) begin
               result.finished = 1'b1;
               result.status   = aborted_ff ? ST_ABORT : ST_OK;
               aborted_in      = 1'b0;
               phase_in        = PH_IDLE;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

// ----- src/rts_out_reg.sv -----
// Result register: holds one result item while the downstream side stalls.
`default_nettype none
module rts_out_reg
   import rts_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  item_valid,
   input  wire rsp_type               result,
   output logic                       take,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata
);

   logic                  valid_ff, valid_in;
   logic [RSP_DATA_W-1:0] data_ff;
   logic                  room;

   assign room     = !valid_ff || rsp_tready;
   assign take     = room && item_valid;
   assign valid_in = room ? item_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         data_ff <= pack_rsp(result);
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;

endmodule
`default_nettype wire

// ----- src/rts_checker.sv -----
// Port-level checks for the sequencer, bound to the top level.
`default_nettype none
module rts_checker
   import rts_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tready,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata
);

   rsp_type r;
   assign r = unpack_rsp(rsp_tdata);

   // both registers come out of reset empty
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_tvalid && req_tready))
      else $error("registers not empty after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result item changed");

   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !r.finished |-> r.status == ST_BUSY)
      else $error("status given without finished");

   a_read_ack: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && r.read_valid |-> (r.bus_command == CMD_ACK || r.bus_command == CMD_NACK))
      else $error("received byte without ack or nack");

   a_req_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (r.data_request || r.finished) |-> r.bus_command == CMD_NONE)
      else $error("bus command alongside data request or finish");

endmodule

bind i2c_register_transaction_sequencer rts_checker u_rts_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire
